// File: sv/x11df_pkg.sv
// shared types, constants and helpers for the x11 stream deframer
package x11df_pkg;

  localparam int DEFAULT_CLIENTS = 8;
  localparam int POS_W           = 18;

  localparam logic [7:0] ORDER_LITTLE = 8'h6C;
  localparam logic [7:0] ORDER_BIG    = 8'h42;

  localparam logic [POS_W-1:0] SETUP_FIXED = 18'd12;

  // byte positions with a meaning inside a message
  localparam logic [POS_W-1:0] POS_ORDER        = 18'd0;
  localparam logic [POS_W-1:0] POS_REQ_LEN_LO   = 18'd2;
  localparam logic [POS_W-1:0] POS_REQ_LEN_HI   = 18'd3;
  localparam logic [POS_W-1:0] POS_AUTH_NAME_LO = 18'd6;
  localparam logic [POS_W-1:0] POS_AUTH_NAME_HI = 18'd7;
  localparam logic [POS_W-1:0] POS_AUTH_DATA_LO = 18'd8;
  localparam logic [POS_W-1:0] POS_AUTH_DATA_HI = 18'd9;

  typedef enum logic [1:0] {
    PHASE_SETUP   = 2'b01,
    PHASE_REQUEST = 2'b10
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_ORDER   = 2'd1,
    STATUS_ZERO_LENGTH = 2'd2,
    STATUS_DROPPED     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_SETUP   = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  typedef struct packed {
    logic [2:0] client_index;
    logic       connection_start;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] client_tag;
    logic [7:0] byte_out;
    logic       big_endian;
    kind_t      message_kind;
    logic       first_of_message;
    logic       last_of_message;
    status_t    status;
  } result_t;

  typedef struct packed {
    phase_t           phase;
    logic             order_big;
    logic [POS_W-1:0] byte_position;
    logic [POS_W-1:0] message_length;
    logic [7:0]       held_byte;
    logic             closed_flag;
  } conn_state_t;

  typedef struct packed {
    logic        en;
    conn_state_t state;
  } conn_write_t;

  localparam conn_state_t CONN_RESET = '{
    phase:          PHASE_SETUP,
    order_big:      1'b0,
    byte_position:  '0,
    message_length: '0,
    held_byte:      8'd0,
    closed_flag:    1'b0
  };

  localparam conn_state_t CONN_CLOSED = '{
    phase:          PHASE_SETUP,
    order_big:      1'b0,
    byte_position:  '0,
    message_length: '0,
    held_byte:      8'd0,
    closed_flag:    1'b1
  };

  // 16-bit field from the held byte and the current one
  function automatic logic [15:0] join16(input logic big, input logic [7:0] held,
                                         input logic [7:0] second);
    logic [15:0] v;
    if (big) begin
      v = {held, second};
    end else begin
      v = {second, held};
    end
    return v;
  endfunction

  // round up to a multiple of four
  function automatic logic [POS_W-1:0] pad4(input logic [15:0] x);
    logic [POS_W-1:0] s;
    s = {2'b00, x} + 18'd3;
    return {s[POS_W-1:2], 2'b00};
  endfunction

endpackage

// File: sv/x11_stream_deframer.sv
// x11 stream deframer top level: input stage, framing logic, result register
//
// Usage: each word on the item channel (item_valid/item_ready) carries one
// byte of one client connection, its client index and a connection start
// flag. Each accepted word yields exactly one result word on the result
// channel (result_valid/result_ready): the byte and its client, the
// connection byte order, the message kind, first/last marks and a status.
// An accepted word is registered in the input stage and then in the result
// register once the result side is free; one word is accepted per cycle
// while the result side does not stall, for any client mix.
// Per-connection state sits in a small memory read when a word is taken
// and written when the word leaves the input stage, with a bypass so that
// back-to-back words of the same client see the freshest state.
// Reset clears the input stage, result_valid and the per-entry valid bits,
// so every connection starts in its setup phase; item_ready stays low
// while rst is high.
// When the receiver stalls, the result is held and one more word can
// still be taken into the input stage; after that item_ready drops.
module x11_stream_deframer #(
  parameter int CLIENTS = x11df_pkg::DEFAULT_CLIENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  x11df_pkg::item_t    item,
  input  logic                item_valid,
  output logic                item_ready,
  output x11df_pkg::result_t  result,
  output logic                result_valid,
  input  logic                result_ready
);

  localparam int AW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

  x11df_pkg::item_t       a_item;
  logic                   a_valid;
  logic                   a_in_range;
  logic                   accept;
  logic                   a_fire;
  logic                   in_range;
  x11df_pkg::conn_state_t cur;
  x11df_pkg::result_t     calc;
  x11df_pkg::conn_write_t calc_wr;
  x11df_pkg::conn_write_t wr;

  assign in_range   = (32'(item.client_index) < CLIENTS);
  assign a_fire     = a_valid && (!result_valid || result_ready);
  assign item_ready = !rst && (!a_valid || a_fire);
  assign accept     = item_valid && item_ready;

  assign wr.en    = a_fire && calc_wr.en;
  assign wr.state = calc_wr.state;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        a_valid <= item_valid;
      end
      if (a_fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item     <= item;
      a_in_range <= in_range;
    end
    if (a_fire) begin
      result <= calc;
    end
  end

  x11df_state_mem #(
    .CLIENTS (CLIENTS),
    .AW      (AW)
  ) u_state_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept && in_range),
    .rd_addr  (AW'(item.client_index)),
    .rd_state (cur),
    .wr       (wr),
    .wr_addr  (AW'(a_item.client_index))
  );

  x11df_frame_logic u_frame_logic (
    .item     (a_item),
    .in_range (a_in_range),
    .cur      (cur),
    .result   (calc),
    .wr       (calc_wr)
  );

endmodule

// File: sv/x11df_state_mem.sv
// per-connection state memory with valid bits and a registered, bypassed read
module x11df_state_mem #(
  parameter int CLIENTS = x11df_pkg::DEFAULT_CLIENTS,
  parameter int AW      = (CLIENTS > 1) ? $clog2(CLIENTS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output x11df_pkg::conn_state_t  rd_state,
  input  x11df_pkg::conn_write_t  wr,
  input  logic [AW-1:0]           wr_addr
);

  x11df_pkg::conn_state_t mem [CLIENTS];
  logic [CLIENTS-1:0]     valid;

  x11df_pkg::conn_state_t rd_raw;
  x11df_pkg::conn_state_t rd_fwd;
  logic                   rd_valid;
  logic                   rd_bypass;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // a write in the same cycle as the read wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
      rd_fwd <= wr.state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      rd_bypass <= 1'b0;
    end else if (rd_en) begin
      rd_valid  <= valid[rd_addr];
      rd_bypass <= wr.en && (wr_addr == rd_addr);
    end
  end

  always_comb begin
    if (rd_bypass) begin
      rd_state = rd_fwd;
    end else if (rd_valid) begin
      rd_state = rd_raw;
    end else begin
      rd_state = x11df_pkg::CONN_RESET;
    end
  end

endmodule

// File: sv/x11df_frame_logic.sv
// per-word framing decision and next connection state
module x11df_frame_logic (
  input  x11df_pkg::item_t        item,
  input  logic                    in_range,
  input  x11df_pkg::conn_state_t  cur,
  output x11df_pkg::result_t      result,
  output x11df_pkg::conn_write_t  wr
);

  x11df_pkg::conn_state_t cs;
  x11df_pkg::conn_state_t nxt;
  x11df_pkg::status_t     st;
  x11df_pkg::kind_t       kind;
  logic [x11df_pkg::POS_W:0]   p1;
  logic [x11df_pkg::POS_W-1:0] pos;
  logic [15:0]            units;
  logic                   big;
  logic                   first;
  logic                   last;
  logic                   drop;

  always_comb begin
    cs    = item.connection_start ? x11df_pkg::CONN_RESET : cur;
    pos   = cs.byte_position;
    p1    = {1'b0, pos} + 19'd1;
    units = x11df_pkg::join16(cs.order_big, cs.held_byte, item.data_byte);
    nxt   = cs;
    st    = x11df_pkg::STATUS_OK;
    kind  = x11df_pkg::KIND_SETUP;
    first = (pos == x11df_pkg::POS_ORDER);
    last  = 1'b0;
    big   = 1'b0;
    drop  = !in_range || (!item.connection_start && cur.closed_flag);

    case (cs.phase)
      x11df_pkg::PHASE_SETUP: begin
        kind = x11df_pkg::KIND_SETUP;
        if (pos == x11df_pkg::POS_ORDER) begin
          if (item.data_byte != x11df_pkg::ORDER_LITTLE &&
              item.data_byte != x11df_pkg::ORDER_BIG) begin
            st = x11df_pkg::STATUS_BAD_ORDER;
          end else begin
            nxt.order_big = (item.data_byte == x11df_pkg::ORDER_BIG);
          end
        end else if (pos == x11df_pkg::POS_AUTH_NAME_LO ||
                     pos == x11df_pkg::POS_AUTH_DATA_LO) begin
          nxt.held_byte = item.data_byte;
        end else if (pos == x11df_pkg::POS_AUTH_NAME_HI) begin
          nxt.message_length = x11df_pkg::SETUP_FIXED + x11df_pkg::pad4(units);
        end else if (pos == x11df_pkg::POS_AUTH_DATA_HI) begin
          nxt.message_length = cs.message_length + x11df_pkg::pad4(units);
        end
        if (st == x11df_pkg::STATUS_OK && pos >= x11df_pkg::POS_AUTH_DATA_HI &&
            p1 == {1'b0, nxt.message_length}) begin
          last = 1'b1;
        end
      end
      default: begin
        // request phase
        kind = x11df_pkg::KIND_REQUEST;
        if (pos == x11df_pkg::POS_REQ_LEN_LO) begin
          nxt.held_byte = item.data_byte;
        end else if (pos == x11df_pkg::POS_REQ_LEN_HI) begin
          if (units == 16'd0) begin
            st = x11df_pkg::STATUS_ZERO_LENGTH;
          end else begin
            nxt.message_length = {units, 2'b00};
          end
        end
        if (st == x11df_pkg::STATUS_OK && pos >= x11df_pkg::POS_REQ_LEN_HI &&
            p1 == {1'b0, nxt.message_length}) begin
          last = 1'b1;
        end
      end
    endcase

    case (st)
      x11df_pkg::STATUS_OK: begin
        big = nxt.order_big;
        if (last) begin
          nxt.byte_position = '0;
          nxt.phase         = x11df_pkg::PHASE_REQUEST;
        end else begin
          nxt.byte_position = p1[x11df_pkg::POS_W-1:0];
        end
      end
      x11df_pkg::STATUS_BAD_ORDER: begin
        nxt   = x11df_pkg::CONN_CLOSED;
        big   = 1'b0;
        kind  = x11df_pkg::KIND_SETUP;
        first = 1'b1;
        last  = 1'b0;
      end
      default: begin
        // zero length request
        big   = cs.order_big;
        nxt   = x11df_pkg::CONN_CLOSED;
        kind  = x11df_pkg::KIND_REQUEST;
        first = 1'b0;
        last  = 1'b0;
      end
    endcase

    if (drop) begin
      st    = x11df_pkg::STATUS_DROPPED;
      big   = 1'b0;
      kind  = x11df_pkg::KIND_SETUP;
      first = 1'b0;
      last  = 1'b0;
    end

    wr.en    = !drop;
    wr.state = nxt;

    result.client_tag       = item.client_index;
    result.byte_out         = item.data_byte;
    result.big_endian       = big;
    result.message_kind     = kind;
    result.first_of_message = first;
    result.last_of_message  = last;
    result.status           = st;
  end

endmodule

// File: dv/tb_x11_stream_deframer.sv
// testbench for x11_stream_deframer: framed client byte streams against a per-byte predictor
`timescale 1ns / 100ps

module tb_x11_stream_deframer;

  localparam int NCONN = x11df_pkg::DEFAULT_CLIENTS;
  localparam int POS_W = x11df_pkg::POS_W;

  class deframer_tracker;
    x11df_pkg::result_t tags_due[$];
    int                 errors;
    x11df_pkg::phase_t  conn_phase  [NCONN];
    logic               conn_big    [NCONN];
    logic [POS_W-1:0]   conn_pos    [NCONN];
    logic [POS_W-1:0]   conn_len    [NCONN];
    logic [7:0]         conn_held   [NCONN];
    logic               conn_closed [NCONN];

    function new();
      errors = 0;
      for (int c = 0; c < NCONN; c++) begin
        clear_conn(c);
      end
    endfunction

    function void clear_conn(int c);
      conn_phase[c]  = x11df_pkg::PHASE_SETUP;
      conn_big[c]    = 1'b0;
      conn_pos[c]    = '0;
      conn_len[c]    = '0;
      conn_held[c]   = 8'd0;
      conn_closed[c] = 1'b0;
    endfunction

    function void close_conn(int c);
      clear_conn(c);
      conn_closed[c] = 1'b1;
    endfunction

    // 16-bit length field from the held byte and this one, in connection order
    function logic [15:0] field16(int c, logic [7:0] b);
      if (conn_big[c]) begin
        return {conn_held[c], b};
      end
      return {b, conn_held[c]};
    endfunction

    function x11df_pkg::result_t frame_byte(x11df_pkg::item_t it);
      x11df_pkg::result_t r;
      int c;
      int p;
      logic [15:0] v;
      c = int'(it.client_index);
      r.client_tag       = it.client_index;
      r.byte_out         = it.data_byte;
      r.big_endian       = 1'b0;
      r.message_kind     = x11df_pkg::KIND_SETUP;
      r.first_of_message = 1'b0;
      r.last_of_message  = 1'b0;
      r.status           = x11df_pkg::STATUS_OK;
      if (!it.connection_start && conn_closed[c]) begin
        r.status = x11df_pkg::STATUS_DROPPED;
        return r;
      end
      if (it.connection_start) begin
        clear_conn(c);
      end
      p = int'(conn_pos[c]);
      r.first_of_message = (p == 0);
      if (conn_phase[c] == x11df_pkg::PHASE_SETUP) begin
        if (p == 0) begin
          if (it.data_byte != x11df_pkg::ORDER_LITTLE &&
              it.data_byte != x11df_pkg::ORDER_BIG) begin
            close_conn(c);
            r.status = x11df_pkg::STATUS_BAD_ORDER;
          end else begin
            conn_big[c] = (it.data_byte == x11df_pkg::ORDER_BIG);
          end
        end else if (p == 6 || p == 8) begin
          conn_held[c] = it.data_byte;
        end else if (p == 7) begin
          v = field16(c, it.data_byte);
          conn_len[c] = POS_W'(int'(x11df_pkg::SETUP_FIXED) + ((int'(v) + 3) & ~3));
        end else if (p == 9) begin
          v = field16(c, it.data_byte);
          conn_len[c] = POS_W'(int'(conn_len[c]) + ((int'(v) + 3) & ~3));
        end
        r.last_of_message = (r.status == x11df_pkg::STATUS_OK && p >= 9 &&
                             p + 1 == int'(conn_len[c]));
      end else begin
        r.message_kind = x11df_pkg::KIND_REQUEST;
        if (p == 2) begin
          conn_held[c] = it.data_byte;
        end else if (p == 3) begin
          v = field16(c, it.data_byte);
          if (v == 16'd0) begin
            r.big_endian = conn_big[c];
            close_conn(c);
            r.status = x11df_pkg::STATUS_ZERO_LENGTH;
          end else begin
            conn_len[c] = POS_W'({v, 2'b00});
          end
        end
        r.last_of_message = (r.status == x11df_pkg::STATUS_OK && p >= 3 &&
                             p + 1 == int'(conn_len[c]));
      end
      if (r.status == x11df_pkg::STATUS_OK) begin
        r.big_endian = conn_big[c];
        if (r.last_of_message) begin
          conn_pos[c]   = '0;
          conn_phase[c] = x11df_pkg::PHASE_REQUEST;
        end else begin
          conn_pos[c] = POS_W'(p + 1);
        end
      end else if (r.status == x11df_pkg::STATUS_BAD_ORDER) begin
        r.big_endian       = 1'b0;
        r.message_kind     = x11df_pkg::KIND_SETUP;
        r.first_of_message = 1'b1;
        r.last_of_message  = 1'b0;
      end else begin
        r.message_kind     = x11df_pkg::KIND_REQUEST;
        r.first_of_message = 1'b0;
        r.last_of_message  = 1'b0;
      end
      return r;
    endfunction

    function void note_byte(x11df_pkg::item_t it);
      tags_due.push_back(frame_byte(it));
    endfunction

    function int pending();
      return tags_due.size();
    endfunction

    task report(string msg);
      if (errors < 20) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) begin
        report($sformatf("%s got %0h expected %0h", name, got, want));
      end
    endtask

    task check_tag(x11df_pkg::result_t got);
      x11df_pkg::result_t want;
      if (tags_due.size() == 0) begin
        report($sformatf("word with nothing due, client %0d byte %02h",
                         got.client_tag, got.byte_out));
        return;
      end
      want = tags_due.pop_front();
      compare_field("client_tag", got.client_tag, want.client_tag);
      compare_field("byte_out", got.byte_out, want.byte_out);
      compare_field("big_endian", got.big_endian, want.big_endian);
      compare_field("message_kind", got.message_kind, want.message_kind);
      compare_field("first_of_message", got.first_of_message, want.first_of_message);
      compare_field("last_of_message", got.last_of_message, want.last_of_message);
      compare_field("status", got.status, want.status);
    endtask
  endclass

  logic               clk;
  logic               rst;
  x11df_pkg::item_t   item;
  logic               item_valid;
  logic               item_ready;
  x11df_pkg::result_t result;
  logic               result_valid;
  logic               result_ready;

  deframer_tracker tracker = new();

  // per-connection byte plans and what the generator believes about each stream
  x11df_pkg::item_t plan [NCONN][$];
  bit    gen_big  [NCONN];
  bit    gen_open [NCONN];

  bit tx_idle;
  bit rx_idle;
  int hold_off_cycles;

  x11_stream_deframer #(
    .CLIENTS(NCONN)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(10ms);
    $display("x11_stream_deframer verification failed");
    $finish;
  end

  function automatic void push(int c, bit st, logic [7:0] b);
    x11df_pkg::item_t w;
    w.client_index     = 3'(c);
    w.connection_start = st;
    w.data_byte        = b;
    plan[c].push_back(w);
  endfunction

  function automatic void push16(int c, int v);
    logic [15:0] f;
    f = 16'(v);
    if (gen_big[c]) begin
      push(c, 1'b0, f[15:8]);
      push(c, 1'b0, f[7:0]);
    end else begin
      push(c, 1'b0, f[7:0]);
      push(c, 1'b0, f[15:8]);
    end
  endfunction

  function automatic void push_noise(int c, int n);
    for (int i = 0; i < n; i++) begin
      push(c, 1'b0, 8'($urandom));
    end
  endfunction

  function automatic void queue_setup(int c, logic [7:0] order, int nlen, int dlen);
    push(c, 1'b1, order);
    if (order != x11df_pkg::ORDER_LITTLE && order != x11df_pkg::ORDER_BIG) begin
      gen_open[c] = 1'b0;
      return;
    end
    gen_big[c]  = (order == x11df_pkg::ORDER_BIG);
    gen_open[c] = 1'b1;
    push_noise(c, 5);
    push16(c, nlen);
    push16(c, dlen);
    push_noise(c, 2 + ((nlen + 3) & ~3) + ((dlen + 3) & ~3));
  endfunction

  function automatic void queue_request(int c, int units);
    push_noise(c, 2);
    push16(c, units);
    if (units == 0) begin
      gen_open[c] = 1'b0;
    end else begin
      push_noise(c, units * 4 - 4);
    end
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(0, 400);
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic int pick_units();
    if ($urandom_range(0, 29) == 0) begin
      return $urandom_range(64, 300);
    end
    return $urandom_range(1, 6);
  endfunction

  function automatic logic [7:0] bad_order();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == x11df_pkg::ORDER_LITTLE || b == x11df_pkg::ORDER_BIG) begin
      b = 8'($urandom);
    end
    return b;
  endfunction

  function automatic void queue_good_setup(int c);
    int n;
    queue_setup(c, $urandom_range(0, 1) ? x11df_pkg::ORDER_BIG : x11df_pkg::ORDER_LITTLE,
                pick_len(), pick_len());
    n = $urandom_range(1, 2);
    for (int i = 0; i < n; i++) begin
      queue_request(c, pick_units());
    end
  endfunction

  // mostly well-formed traffic, with broken and stray bytes mixed in
  function automatic void refill(int c);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (!gen_open[c]) begin
      if (r < 75) begin
        queue_good_setup(c);
      end else if (r < 90) begin
        queue_setup(c, bad_order(), 0, 0);
        push_noise(c, $urandom_range(0, 3));
      end else begin
        push_noise(c, $urandom_range(1, 4));
      end
    end else begin
      if (r < 78) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          queue_request(c, pick_units());
        end
      end else if (r < 86) begin
        queue_request(c, 0);
      end else if (r < 93) begin
        queue_good_setup(c);
      end else begin
        push_noise(c, $urandom_range(1, 6));
      end
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_word(x11df_pkg::item_t w);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!item_ready);
    tracker.note_byte(w);
    @(negedge clk);
  endtask

  task automatic send_plans();
    for (int c = 0; c < NCONN; c++) begin
      while (plan[c].size() != 0) begin
        send_word(plan[c].pop_front());
      end
    end
  endtask

  task automatic send_random(int count);
    int sent;
    int c;
    sent = 0;
    c    = 0;
    while (sent < count) begin
      // stay on the same connection about half the time
      if ($urandom_range(0, 1) == 1) begin
        c = $urandom_range(0, NCONN - 1);
      end
      // a new connection cutting into an unfinished message
      if ($urandom_range(0, 199) == 0) begin
        plan[c].delete();
        queue_good_setup(c);
      end
      if (plan[c].size() == 0) begin
        refill(c);
      end
      send_word(plan[c].pop_front());
      sent++;
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) begin
      @(negedge clk);
    end
    forever begin
      if (hold_off_cycles > 0) begin
        result_ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      stall = rx_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!result_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      tracker.check_tag(result);
    end
  end

  initial begin
    rst             = 1'b1;
    item            = '0;
    item_valid      = 1'b0;
    tx_idle         = 1'b0;
    rx_idle         = 1'b0;
    hold_off_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // big-endian setup, short and zero-length requests, a dropped word, two new connections
    queue_setup(0, x11df_pkg::ORDER_BIG, 0, 0);
    queue_request(0, 1);
    queue_request(0, 0);
    push(0, 1'b0, 8'hFF);
    push(1, 1'b1, 8'h00);
    push(7, 1'b1, x11df_pkg::ORDER_LITTLE);
    send_plans();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle = (ph == 0 || ph == 3);
      rx_idle = (ph == 0 || ph == 2);
      if (ph == 2) begin
        hold_off_cycles = 400;
      end
      send_random(425);
      drain();
    end

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("x11_stream_deframer verification clean");
    end else begin
      $display("x11_stream_deframer verification failed");
    end
    $finish;
  end

endmodule
